>>> hdl/tns_pkg.sv
// Shared types and constants of the timed note sequencer.
// No dependencies; imported by every other file of the block.
`default_nettype none

package tns_pkg;

    localparam int NOTE_W          = 7;
    localparam int TIME_W          = 32;
    localparam int REQ_W           = 2;
    localparam int MAX_HITS_DEF    = 64;
    localparam int MAX_TRACKS_DEF  = 16;
    localparam int OUT_LIMIT       = 64;
    localparam int IN_TDATA_W      = ((NOTE_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W     = ((NOTE_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W     = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Request codes carried in the input tuser.
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_QUEUE = 2'd1,
        REQ_TICK  = 2'd2
    } t_req;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RESP  = 9'b000000010,
        ST_Q_RD  = 9'b000000100,
        ST_Q_SUM = 9'b000001000,
        ST_Q_WR  = 9'b000010000,
        ST_S_HIT = 9'b000100000,
        ST_S_TRK = 9'b001000000,
        ST_S_CHK = 9'b010000000,
        ST_FLUSH = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

>>> hdl/timed_note_sequencer.sv
// Top level of the timed note sequencer: hit and track stores, sequencer, output register.
// Depends on tns_pkg and on the shared adder tns_sat_add.
`default_nettype none

// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: note, time_ms; tuser: req_type
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: note_out; tuser: note_valid, status;
//                                               tlast: last
//
// An add-hit item and a refused item pass through ST_RESP; a queue item through ST_Q_WR
// and ST_RESP with no track queued yet, else ST_Q_RD, ST_Q_SUM, ST_Q_WR, ST_RESP. A tick
// walks the hit store one entry at a time: ST_S_HIT and ST_S_TRK for a hit of the open
// track, ST_S_CHK too for a queued track's hit, plus the accepting state, the end check
// and the flush; the single hit-store read port and the one saturating adder set this pace.
// Reset clears the counters and empties the output register at once; the stores are
// not cleared, since only written entries are ever read. A stalled output holds the
// sequencer where it would need to load another item, and s_axis_tready stays low
// until an item's last result is in the output register.

module timed_note_sequencer
    import tns_pkg::*;
#(
    parameter int MAX_HITS   = MAX_HITS_DEF,
    parameter int MAX_TRACKS = MAX_TRACKS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // Bits from the lowest up: note (7), time_ms (32), zero padding (1).
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Bits from the lowest up: req_type (2).
    input  wire logic [REQ_W-1:0]       s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // Bits from the lowest up: note_out (7), zero padding (1).
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // Bits from the lowest up: note_valid (1), status (1).
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int HCNT_W = $clog2(MAX_HITS + 1);
    localparam int HIDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int TCNT_W = $clog2(MAX_TRACKS + 1);
    localparam int TID_W  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int ECNT_W = $clog2(OUT_LIMIT + 1);

    // Input fields.
    logic [NOTE_W-1:0] in_note;
    logic [TIME_W-1:0] in_time;

    assign in_note = s_axis_tdata[NOTE_W-1:0];
    assign in_time = s_axis_tdata[NOTE_W +: TIME_W];

    // Stores. Each hit remembers the track that was open when it was added.
    logic [NOTE_W-1:0] r_hit_notes  [MAX_HITS];
    logic [TIME_W-1:0] r_hit_times  [MAX_HITS];
    logic [TID_W-1:0]  r_hit_tids   [MAX_HITS];
    logic [TIME_W-1:0] r_trk_starts [MAX_TRACKS];
    logic [TIME_W-1:0] r_trk_durs   [MAX_TRACKS];

    // Registered read data of the stores.
    logic [NOTE_W-1:0] r_hrd_note;
    logic [TIME_W-1:0] r_hrd_time;
    logic [TID_W-1:0]  r_hrd_tid;
    logic [TIME_W-1:0] r_trd_start;
    logic [TIME_W-1:0] r_trd_dur;

    // Control state.
    t_state            r_state, n_state;
    logic [HCNT_W-1:0] r_hit_count, n_hit_count;
    logic [TCNT_W-1:0] r_trk_count, n_trk_count;
    logic [TIME_W-1:0] r_open_dur, n_open_dur;
    logic [TIME_W-1:0] r_last_tick, n_last_tick;
    logic              r_pend_valid, n_pend_valid;
    logic              r_out_valid, n_out_valid;

    // Working registers of the sequencer.
    logic [TIME_W-1:0] r_now, n_now;
    logic [HCNT_W-1:0] r_idx, n_idx;
    logic [ECNT_W-1:0] r_emit_cnt, n_emit_cnt;
    logic [NOTE_W-1:0] r_pend_note, n_pend_note;
    logic [TIME_W-1:0] r_acc, n_acc;
    logic              r_status, n_status;
    logic [NOTE_W-1:0] r_out_note, n_out_note;
    logic              r_out_nv, n_out_nv;
    logic              r_out_last, n_out_last;
    logic              r_out_status, n_out_status;

    // Store strobes and addresses.
    logic              hit_wr;
    logic              hrd_en;
    logic              trk_wr;
    logic              trd_en;
    logic [TCNT_W-1:0] trk_last;
    logic [TID_W-1:0]  trk_raddr;
    logic [TIME_W-1:0] trk_wstart;

    // Shared adder.
    logic [TIME_W-1:0] add_a;
    logic [TIME_W-1:0] add_b;
    logic [TIME_W-1:0] add_sum;

    logic              out_free;
    logic              due;

    tns_sat_add u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .o_sum (add_sum)
    );

    // The adder forms a hit's absolute time during the scan, the end of the
    // previous track while queuing, and one past the last tick otherwise.
    always_comb begin
        if (r_state == ST_S_CHK) begin
            add_a = r_trd_start;
            add_b = r_hrd_time;
        end else if (r_state == ST_Q_SUM) begin
            add_a = r_trd_start;
            add_b = r_trd_dur;
        end else begin
            add_a = r_last_tick;
            add_b = TIME_W'(1);
        end
    end

    assign trk_last   = r_trk_count - TCNT_W'(1);
    assign trk_raddr  = (r_state == ST_Q_RD) ? trk_last[TID_W-1:0] : r_hrd_tid;
    assign trk_wstart = (r_acc > r_last_tick) ? r_acc : add_sum;
    assign due        = (add_sum >= r_last_tick) && (add_sum < r_now);
    assign out_free   = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_note);
    assign m_axis_tuser  = {r_out_status, r_out_nv};
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        n_state      = r_state;
        n_hit_count  = r_hit_count;
        n_trk_count  = r_trk_count;
        n_open_dur   = r_open_dur;
        n_last_tick  = r_last_tick;
        n_pend_valid = r_pend_valid;
        n_now        = r_now;
        n_idx        = r_idx;
        n_emit_cnt   = r_emit_cnt;
        n_pend_note  = r_pend_note;
        n_acc        = r_acc;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_note   = r_out_note;
        n_out_nv     = r_out_nv;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        hit_wr       = 1'b0;
        hrd_en       = 1'b0;
        trk_wr       = 1'b0;
        trd_en       = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (s_axis_tuser)
                        REQ_ADD: begin
                            n_state = ST_RESP;
                            if (r_hit_count >= HCNT_W'(MAX_HITS) ||
                                r_trk_count >= TCNT_W'(MAX_TRACKS)) begin
                                n_status = 1'b1;
                            end else begin
                                n_status    = 1'b0;
                                hit_wr      = 1'b1;
                                n_hit_count = r_hit_count + HCNT_W'(1);
                                if (in_time > r_open_dur) begin
                                    n_open_dur = in_time;
                                end
                            end
                        end
                        REQ_QUEUE: begin
                            n_status = 1'b0;
                            if (r_trk_count >= TCNT_W'(MAX_TRACKS)) begin
                                n_status = 1'b1;
                                n_state  = ST_RESP;
                            end else if (r_trk_count == '0) begin
                                // No previous track: its end counts as zero.
                                n_acc   = '0;
                                n_state = ST_Q_WR;
                            end else begin
                                n_state = ST_Q_RD;
                            end
                        end
                        REQ_TICK: begin
                            n_now        = in_time;
                            n_idx        = '0;
                            n_emit_cnt   = '0;
                            n_pend_valid = 1'b0;
                            n_state      = ST_S_HIT;
                        end
                        default: begin
                            n_status = 1'b0;
                            n_state  = ST_RESP;
                        end
                    endcase
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_note   = '0;
                    n_out_nv     = 1'b0;
                    n_out_last   = 1'b1;
                    n_out_status = r_status;
                    n_state      = ST_IDLE;
                end
            end
            ST_Q_RD: begin
                trd_en  = 1'b1;
                n_state = ST_Q_SUM;
            end
            ST_Q_SUM: begin
                n_acc   = add_sum;
                n_state = ST_Q_WR;
            end
            ST_Q_WR: begin
                trk_wr      = 1'b1;
                n_trk_count = r_trk_count + TCNT_W'(1);
                n_open_dur  = '0;
                n_state     = ST_RESP;
            end
            ST_S_HIT: begin
                if (r_idx >= r_hit_count) begin
                    n_state = ST_FLUSH;
                end else begin
                    hrd_en  = 1'b1;
                    n_state = ST_S_TRK;
                end
            end
            ST_S_TRK: begin
                // Hits of the open track are not yet scheduled.
                if (TCNT_W'(r_hrd_tid) >= r_trk_count) begin
                    n_idx   = r_idx + HCNT_W'(1);
                    n_state = ST_S_HIT;
                end else begin
                    trd_en  = 1'b1;
                    n_state = ST_S_CHK;
                end
            end
            ST_S_CHK: begin
                if (!due) begin
                    n_idx   = r_idx + HCNT_W'(1);
                    n_state = ST_S_HIT;
                end else if (!r_pend_valid || out_free) begin
                    // The held note goes out only once another one follows it,
                    // so that the final note of the tick can carry last.
                    if (r_pend_valid) begin
                        n_out_valid  = 1'b1;
                        n_out_note   = r_pend_note;
                        n_out_nv     = 1'b1;
                        n_out_last   = 1'b0;
                        n_out_status = 1'b0;
                    end
                    n_pend_note  = r_hrd_note;
                    n_pend_valid = 1'b1;
                    n_emit_cnt   = r_emit_cnt + ECNT_W'(1);
                    n_idx        = r_idx + HCNT_W'(1);
                    n_state      = (n_emit_cnt == ECNT_W'(OUT_LIMIT)) ? ST_FLUSH : ST_S_HIT;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_note   = r_pend_valid ? r_pend_note : '0;
                    n_out_nv     = r_pend_valid;
                    n_out_last   = 1'b1;
                    n_out_status = 1'b0;
                    n_pend_valid = 1'b0;
                    n_last_tick  = r_now;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hit_count  <= '0;
            r_trk_count  <= '0;
            r_open_dur   <= '0;
            r_last_tick  <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hit_count  <= n_hit_count;
            r_trk_count  <= n_trk_count;
            r_open_dur   <= n_open_dur;
            r_last_tick  <= n_last_tick;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now        <= n_now;
        r_idx        <= n_idx;
        r_emit_cnt   <= n_emit_cnt;
        r_pend_note  <= n_pend_note;
        r_acc        <= n_acc;
        r_status     <= n_status;
        r_out_note   <= n_out_note;
        r_out_nv     <= n_out_nv;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    // Hit store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (hit_wr) begin
            r_hit_notes[r_hit_count[HIDX_W-1:0]] <= in_note;
            r_hit_times[r_hit_count[HIDX_W-1:0]] <= in_time;
            r_hit_tids[r_hit_count[HIDX_W-1:0]]  <= r_trk_count[TID_W-1:0];
        end
        if (hrd_en) begin
            r_hrd_note <= r_hit_notes[r_idx[HIDX_W-1:0]];
            r_hrd_time <= r_hit_times[r_idx[HIDX_W-1:0]];
            r_hrd_tid  <= r_hit_tids[r_idx[HIDX_W-1:0]];
        end
    end

    // Track store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (trk_wr) begin
            r_trk_starts[r_trk_count[TID_W-1:0]] <= trk_wstart;
            r_trk_durs[r_trk_count[TID_W-1:0]]   <= r_open_dur;
        end
        if (trd_en) begin
            r_trd_start <= r_trk_starts[trk_raddr];
            r_trd_dur   <= r_trk_durs[trk_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/tns_sat_add.sv
// Shared saturating time adder of the timed note sequencer.
// Depends on tns_pkg for the time width and the saturation value.
`default_nettype none

module tns_sat_add
    import tns_pkg::*;
(
    input  wire logic [TIME_W-1:0] i_a,
    input  wire logic [TIME_W-1:0] i_b,
    output logic      [TIME_W-1:0] o_sum
);

    logic [TIME_W:0] full_sum;

    // A carry out of the top bit means the time ran past its range.
    assign full_sum = {1'b0, i_a} + {1'b0, i_b};
    assign o_sum    = full_sum[TIME_W] ? TIME_MAX : full_sum[TIME_W-1:0];

endmodule

`default_nettype wire

>>> hdl/tns_checker.sv
// Port-level checks of the timed note sequencer, bound to its top level.
// Depends on tns_pkg for the port widths and on timed_note_sequencer.
`default_nettype none

module tns_checker
    import tns_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input  wire logic                   m_axis_tlast
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output item present after reset");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // An accepted item leaves the block busy in the cycle after the handshake.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready high right after an accepted item");

    // A result without a note is always the final one and carries no note bits;
    // a refused item never carries a note.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (!m_axis_tuser[0] || m_axis_tuser[1]) |->
            !m_axis_tuser[0] && m_axis_tlast && (m_axis_tdata == '0))
        else $error("malformed result without a note");

endmodule

bind timed_note_sequencer tns_checker u_tns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of timed_note_sequencer: directed items, random phrases, full stores.
// Needs tns_pkg and the sequencer RTL; expected items come from a behavioral copy kept here.

module tb;
    import tns_pkg::*;

    // The unused request code is not part of the package enum.
    localparam logic [REQ_W-1:0] REQ_RSVD = 2'd3;
    // Longest run of cycles without any handshake before the run is declared hung.
    // A tick that scans 64 hits with nothing due is the longest busy stretch, and
    // sender gaps and receiver stalls add to it.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles left for stray items after the last expected one has arrived.
    localparam int TAIL_CYCLES = 300;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic              valid;
        logic              last;
        logic              status;
    } t_note_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Bits from the lowest up: note (7), time_ms (32), zero padding (1).
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // Bits from the lowest up: req_type (2).
    logic [REQ_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Bits from the lowest up: note_out (7), zero padding (1).
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // Bits from the lowest up: note_valid (1), status (1).
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    timed_note_sequencer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // Behavioral copy of the sequencer state. The stores are only read where
    // they have been written, so they need no reset value.
    logic [NOTE_W-1:0] hit_note_mem [0:MAX_HITS_DEF-1];
    logic [TIME_W-1:0] hit_time_mem [0:MAX_HITS_DEF-1];
    logic [3:0]        hit_trk_mem  [0:MAX_HITS_DEF-1];
    logic [TIME_W-1:0] trk_start_mem [0:MAX_TRACKS_DEF-1];
    logic [TIME_W-1:0] trk_dur_mem   [0:MAX_TRACKS_DEF-1];
    int                hit_cnt = 0;
    int                trk_cnt = 0;
    logic [TIME_W-1:0] open_dur = '0;
    logic [TIME_W-1:0] last_tick = '0;

    t_note_result expected_notes [$];
    int           mismatches = 0;
    int           burst_left = 0;

    // Millisecond sums clamp at the largest time instead of wrapping.
    function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // Updates the copied state for one accepted item and queues the items it
    // should produce on the output.
    task automatic compute_note_results(input logic [REQ_W-1:0] req,
                                        input logic [NOTE_W-1:0] note,
                                        input logic [TIME_W-1:0] tms);
        t_note_result      r;
        t_note_result      held;
        bit                have_held;
        int                emitted;
        logic [TIME_W-1:0] prev_end;
        logic [TIME_W-1:0] abs_ms;
        r = '0;
        r.last = 1'b1;
        held = '0;
        have_held = 0;
        emitted = 0;
        if (req == REQ_TICK) begin
            // Every hit of a queued track whose absolute time falls in the
            // window [last tick, now) is played, in store order.
            for (int i = 0; i < hit_cnt; i++) begin
                if (hit_trk_mem[i] < trk_cnt) begin
                    abs_ms = sat_sum(trk_start_mem[hit_trk_mem[i]], hit_time_mem[i]);
                    if (abs_ms >= last_tick && abs_ms < tms) begin
                        if (emitted >= OUT_LIMIT) break;
                        if (have_held)
                            expected_notes.insert(expected_notes.size(), held);
                        held = '0;
                        held.note = hit_note_mem[i];
                        held.valid = 1'b1;
                        have_held = 1;
                        emitted++;
                    end
                end
            end
            last_tick = tms;
            if (have_held) begin
                held.last = 1'b1;
                expected_notes.insert(expected_notes.size(), held);
            end else begin
                expected_notes.insert(expected_notes.size(), r);
            end
        end else begin
            case (req)
                REQ_ADD: begin
                    if (hit_cnt >= MAX_HITS_DEF || trk_cnt >= MAX_TRACKS_DEF) begin
                        r.status = 1'b1;
                    end else begin
                        hit_note_mem[hit_cnt] = note;
                        hit_time_mem[hit_cnt] = tms;
                        hit_trk_mem[hit_cnt] = 4'(trk_cnt);
                        hit_cnt++;
                        if (tms > open_dur) open_dur = tms;
                    end
                end
                REQ_QUEUE: begin
                    if (trk_cnt >= MAX_TRACKS_DEF) begin
                        r.status = 1'b1;
                    end else begin
                        prev_end = '0;
                        if (trk_cnt > 0)
                            prev_end = sat_sum(trk_start_mem[trk_cnt-1], trk_dur_mem[trk_cnt-1]);
                        // A new track starts when the previous one ends, but never
                        // earlier than one millisecond after the last tick.
                        trk_start_mem[trk_cnt] = (prev_end > last_tick) ? prev_end
                                                 : sat_sum(last_tick, TIME_W'(1));
                        trk_dur_mem[trk_cnt] = open_dur;
                        trk_cnt++;
                        open_dur = '0;
                    end
                end
                default: begin
                    // The unused code is answered with one empty item.
                end
            endcase
            expected_notes.insert(expected_notes.size(), r);
        end
    endtask

    // Sends one item. The sender works in bursts; between bursts tvalid is
    // dropped for a random number of cycles, and sometimes not at all.
    task automatic send_item(input logic [REQ_W-1:0] req,
                             input logic [NOTE_W-1:0] note,
                             input logic [TIME_W-1:0] tms);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, tms, note};
        s_axis_tuser  <= req;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        compute_note_results(req, note, tms);
    endtask

    // Stops sending and waits until every expected item has been seen.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_notes.size() != 0) @(posedge i_clk);
    endtask

    // Hand-picked items: empty windows, notes at both ends of their range,
    // hits of the open track skipped by a tick, ticks at time zero and at the
    // largest time, a tick going backwards, the unused code, an empty track.
    task automatic test_directed();
        send_item(REQ_TICK, 7'd0, 32'd0);
        send_item(REQ_ADD, 7'd0, 32'd0);
        send_item(REQ_ADD, 7'd127, 32'd5);
        send_item(REQ_ADD, 7'h55, 32'd5);
        send_item(REQ_QUEUE, 7'd0, 32'd0);
        send_item(REQ_TICK, 7'd0, 32'd1);
        send_item(REQ_TICK, 7'd0, 32'd7);
        send_item(REQ_TICK, 7'd0, 32'd7);
        send_item(REQ_ADD, 7'h2A, 32'd3);
        send_item(REQ_TICK, 7'd0, 32'd20);
        send_item(REQ_QUEUE, 7'd127, TIME_MAX);
        send_item(REQ_TICK, 7'd0, TIME_MAX);
        send_item(REQ_TICK, 7'd0, 32'd10);
        send_item(REQ_RSVD, 7'd127, TIME_MAX);
        send_item(REQ_TICK, 7'd0, 32'd30);
        send_item(REQ_QUEUE, 7'd0, 32'd0);
    endtask

    // Random phrases: a few hits, usually queued, followed by ticks that walk
    // time forward, mixed with backward ticks and unused-code items.
    task automatic test_random_phrases();
        int                sent;
        int                k;
        logic [TIME_W-1:0] now_ms;
        sent = 0;
        now_ms = last_tick;
        while (sent < 280) begin
            // Store room is kept back for the full-store test that follows.
            if (trk_cnt < 12 && hit_cnt < 48 && $urandom_range(0, 2) != 0) begin
                k = $urandom_range(0, 4);
                repeat (k) begin
                    send_item(REQ_ADD, NOTE_W'($urandom_range(0, 127)),
                              $urandom_range(0, 60));
                    sent++;
                end
                if ($urandom_range(0, 4) != 0) begin
                    send_item(REQ_QUEUE, NOTE_W'($urandom_range(0, 127)), $urandom);
                    sent++;
                end
            end
            k = $urandom_range(1, 5);
            repeat (k) begin
                case ($urandom_range(0, 9))
                    0: send_item(REQ_RSVD, NOTE_W'($urandom_range(0, 127)), $urandom);
                    1: send_item(REQ_TICK, NOTE_W'($urandom_range(0, 127)),
                                 now_ms - $urandom_range(0, 20));
                    default: begin
                        now_ms = now_ms + $urandom_range(1, 40);
                        send_item(REQ_TICK, NOTE_W'($urandom_range(0, 127)), now_ms);
                    end
                endcase
                sent++;
            end
        end
    endtask

    // Fills the hit store, then the track store, with saturating start times
    // on the way, and ends with a run of ticks, one of which plays nearly every hit.
    task automatic test_full_stores();
        while (hit_cnt < MAX_HITS_DEF - 2)
            send_item(REQ_ADD, NOTE_W'($urandom_range(0, 127)), $urandom_range(0, 60));
        send_item(REQ_QUEUE, 7'd0, 32'd0);
        // After a tick at the largest time the next start clamps there.
        send_item(REQ_TICK, 7'd0, TIME_MAX);
        send_item(REQ_ADD, NOTE_W'($urandom_range(0, 127)), TIME_MAX);
        send_item(REQ_QUEUE, 7'd0, 32'd0);
        // The last free hit; its track start clamps as start plus duration.
        send_item(REQ_ADD, NOTE_W'($urandom_range(0, 127)), 32'd7);
        // The hit store is full while tracks are still free.
        send_item(REQ_ADD, NOTE_W'($urandom_range(0, 127)), 32'd9);
        while (trk_cnt < MAX_TRACKS_DEF)
            send_item(REQ_QUEUE, 7'd0, 32'd0);
        send_item(REQ_QUEUE, 7'd0, 32'd0);
        send_item(REQ_ADD, NOTE_W'($urandom_range(0, 127)), 32'd1);
        send_item(REQ_TICK, 7'd0, 32'd0);
        send_item(REQ_TICK, 7'd0, TIME_MAX - 1);
        send_item(REQ_TICK, 7'd0, TIME_MAX);
        repeat (8) send_item(REQ_TICK, NOTE_W'($urandom_range(0, 127)), $urandom);
    endtask

    // The receiver follows a 32-bit ready pattern that is redrawn each
    // time it wraps; about one pattern in four never stalls.
    logic [31:0] stall_pat = '1;
    logic [4:0]  stall_idx = '0;
    always @(negedge i_clk) begin
        if (stall_idx == 5'd0)
            stall_pat <= ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
        m_axis_tready <= stall_pat[stall_idx];
        stall_idx <= stall_idx + 5'd1;
    end

    // Each output item is compared with the oldest expected one.
    t_note_result got_item;
    t_note_result want_item;
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_item.note   = m_axis_tdata[NOTE_W-1:0];
            got_item.valid  = m_axis_tuser[0];
            got_item.status = m_axis_tuser[1];
            got_item.last   = m_axis_tlast;
            if (expected_notes.size() == 0) begin
                $display("%0t: unexpected item: note %0d valid %0b last %0b status %0b",
                         $time, got_item.note, got_item.valid, got_item.last,
                         got_item.status);
                mismatches++;
            end else begin
                want_item = expected_notes.pop_front();
                if (got_item !== want_item) begin
                    $display("%0t: mismatch: expected note %0d valid %0b last %0b status %0b,",
                             $time, want_item.note, want_item.valid, want_item.last,
                             want_item.status);
                    $display("%0t:           actual   note %0d valid %0b last %0b status %0b",
                             $time, got_item.note, got_item.valid, got_item.last,
                             got_item.status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run if no handshake happens on either side for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("timed_note_sequencer verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        // The sender holds off here until every expected item has come back.
        drain_results();
        test_random_phrases();
        drain_results();
        test_full_stores();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("timed_note_sequencer verification clean");
        end else begin
            $display("timed_note_sequencer verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/tns_pkg.sv
hdl/tns_sat_add.sv
hdl/timed_note_sequencer.sv
hdl/tns_checker.sv
sim/tb.sv
